// ----- rtl/core/rb2d_pkg.sv -----
`timescale 1ns / 1ps

package rb2d_pkg;

    localparam int FRAC_BITS = 16;
    localparam int STEP_FRAC = 16;
    localparam int PROD_W    = 66;
    localparam int UC_IDX_W  = 4;
    localparam int APB_AW    = 5;

    localparam logic [30:0] INV_MASS_RST    = 31'(64'd1 << FRAC_BITS);
    localparam logic [30:0] INV_INERTIA_RST = 31'((64'd3754936 << FRAC_BITS) >> 16);
    localparam logic [16:0] STEP_ONE        = 17'd65536;
    localparam logic [32:0] DF_ONE          = 33'(64'd1 << FRAC_BITS);

    typedef enum logic [2:0] {
        OP_TICK       = 3'd0,
        OP_FORCE      = 3'd1,
        OP_TORQUE     = 3'd2,
        OP_FORCE_AT   = 3'd3,
        OP_IMPULSE    = 3'd4,
        OP_IMPULSE_AT = 3'd5,
        OP_SET_POSE   = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        REG_DYN_EN      = 3'd0,
        REG_INV_MASS    = 3'd1,
        REG_INV_INERTIA = 3'd2,
        REG_LIN_DRAG    = 3'd3,
        REG_ANG_DRAG    = 3'd4,
        REG_RESTRICT_X  = 3'd5,
        REG_RESTRICT_Y  = 3'd6,
        REG_RESTRICT_S  = 3'd7
    } reg_idx_t;

    // Micro-operations: one multiply each, result written back in the cycle after issue.
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_VX_ACC,
        UOP_VY_ACC,
        UOP_VX_KEEP,
        UOP_VY_KEEP,
        UOP_LIN_DF,
        UOP_W_ACC,
        UOP_VX_DF,
        UOP_VY_DF,
        UOP_W_KEEP,
        UOP_ANG_DF,
        UOP_PX_ADD,
        UOP_W_DF,
        UOP_PY_ADD,
        UOP_ANG_ADD,
        UOP_AX_FORCE,
        UOP_AY_FORCE,
        UOP_AW_TORQUE,
        UOP_AW_MOMENT,
        UOP_LEV_1,
        UOP_LEV_2,
        UOP_VX_IMP,
        UOP_VY_IMP,
        UOP_W_IMP,
        UOP_W_IMP_MOMENT,
        UOP_POSE
    } uop_t;

    typedef struct packed {
        uop_t uop;
        logic last;
    } ucode_t;

    typedef struct packed {
        logic        dynamic_enable;
        logic [30:0] inv_mass;
        logic [30:0] inv_inertia_deg;
        logic [30:0] linear_drag;
        logic [30:0] angular_drag;
        logic [16:0] restrict_x;
        logic [16:0] restrict_y;
        logic [16:0] restrict_spin;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic issue;
        uop_t uop;
        logic publish;
    } ctrl_cmd_t;

    // Micro-program for each opcode. A dependent step is always placed at
    // least two slots after the step that produces its operand.
    function automatic ucode_t ucode(op_t op, logic [UC_IDX_W-1:0] idx);
        ucode_t u;
        u.uop  = UOP_NONE;
        u.last = 1'b1;
        unique case (op)
            OP_TICK: begin
                u.last = 1'b0;
                unique case (idx)
                    4'd0:  u.uop = UOP_VX_ACC;
                    4'd1:  u.uop = UOP_VY_ACC;
                    4'd2:  u.uop = UOP_VX_KEEP;
                    4'd3:  u.uop = UOP_VY_KEEP;
                    4'd4:  u.uop = UOP_LIN_DF;
                    4'd5:  u.uop = UOP_W_ACC;
                    4'd6:  u.uop = UOP_VX_DF;
                    4'd7:  u.uop = UOP_VY_DF;
                    4'd8:  u.uop = UOP_W_KEEP;
                    4'd9:  u.uop = UOP_ANG_DF;
                    4'd10: u.uop = UOP_PX_ADD;
                    4'd11: u.uop = UOP_W_DF;
                    4'd12: u.uop = UOP_PY_ADD;
                    default: begin
                        u.uop  = UOP_ANG_ADD;
                        u.last = 1'b1;
                    end
                endcase
            end
            OP_FORCE: begin
                u.uop  = (idx == 4'd0) ? UOP_AX_FORCE : UOP_AY_FORCE;
                u.last = (idx != 4'd0);
            end
            OP_TORQUE: begin
                u.uop = UOP_AW_TORQUE;
            end
            OP_FORCE_AT: begin
                u.last = 1'b0;
                unique case (idx)
                    4'd0: u.uop = UOP_LEV_1;
                    4'd1: u.uop = UOP_LEV_2;
                    4'd2: u.uop = UOP_AX_FORCE;
                    4'd3: u.uop = UOP_AY_FORCE;
                    default: begin
                        u.uop  = UOP_AW_MOMENT;
                        u.last = 1'b1;
                    end
                endcase
            end
            OP_IMPULSE: begin
                u.last = 1'b0;
                unique case (idx)
                    4'd0: u.uop = UOP_VX_IMP;
                    4'd1: u.uop = UOP_VY_IMP;
                    default: begin
                        u.uop  = UOP_W_IMP;
                        u.last = 1'b1;
                    end
                endcase
            end
            OP_IMPULSE_AT: begin
                u.last = 1'b0;
                unique case (idx)
                    4'd0: u.uop = UOP_LEV_1;
                    4'd1: u.uop = UOP_LEV_2;
                    4'd2: u.uop = UOP_VX_IMP;
                    4'd3: u.uop = UOP_VY_IMP;
                    default: begin
                        u.uop  = UOP_W_IMP_MOMENT;
                        u.last = 1'b1;
                    end
                endcase
            end
            OP_SET_POSE: begin
                u.uop = UOP_POSE;
            end
            default: begin
                u.uop = UOP_NONE;
            end
        endcase
        return u;
    endfunction

endpackage

// ----- rtl/core/rb2d_regs.sv -----
`timescale 1ns / 1ps

module rb2d_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rb2d_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output rb2d_pkg::cfg_t               cfg
);
    import rb2d_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DYN_EN:      cfg_next.dynamic_enable  = pwdata[0];
                REG_INV_MASS:    cfg_next.inv_mass        = pwdata[30:0];
                REG_INV_INERTIA: cfg_next.inv_inertia_deg = pwdata[30:0];
                REG_LIN_DRAG:    cfg_next.linear_drag     = pwdata[30:0];
                REG_ANG_DRAG:    cfg_next.angular_drag    = pwdata[30:0];
                REG_RESTRICT_X:  cfg_next.restrict_x      = pwdata[16:0];
                REG_RESTRICT_Y:  cfg_next.restrict_y      = pwdata[16:0];
                default:         cfg_next.restrict_spin   = pwdata[16:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DYN_EN:      prdata = {31'd0, cfg_reg.dynamic_enable};
            REG_INV_MASS:    prdata = {1'b0, cfg_reg.inv_mass};
            REG_INV_INERTIA: prdata = {1'b0, cfg_reg.inv_inertia_deg};
            REG_LIN_DRAG:    prdata = {1'b0, cfg_reg.linear_drag};
            REG_ANG_DRAG:    prdata = {1'b0, cfg_reg.angular_drag};
            REG_RESTRICT_X:  prdata = {15'd0, cfg_reg.restrict_x};
            REG_RESTRICT_Y:  prdata = {15'd0, cfg_reg.restrict_y};
            default:         prdata = {15'd0, cfg_reg.restrict_spin};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dynamic_enable  <= 1'b0;
            cfg_reg.inv_mass        <= INV_MASS_RST;
            cfg_reg.inv_inertia_deg <= INV_INERTIA_RST;
            cfg_reg.linear_drag     <= '0;
            cfg_reg.angular_drag    <= '0;
            cfg_reg.restrict_x      <= '0;
            cfg_reg.restrict_y      <= '0;
            cfg_reg.restrict_spin   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/rb2d_ctrl.sv -----
`timescale 1ns / 1ps

module rb2d_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            opcode,
    input  logic                  dynamic_enable,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rb2d_pkg::ctrl_cmd_t   cmd
);
    import rb2d_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [UC_IDX_W-1:0]   idx_reg, idx_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  accept;
    logic                  skip;
    logic                  can_publish;
    ucode_t                uc;

    assign in_ready    = (state_reg == S_IDLE);
    assign accept      = in_valid & in_ready;
    assign out_valid   = out_valid_reg;
    assign can_publish = ~out_valid_reg | out_ready;
    assign uc          = ucode(op_reg, idx_reg);

    // A tick on a static body and the unused opcode leave the state alone.
    assign skip = (op_t'(opcode) == OP_NOP)
               || ((op_t'(opcode) == OP_TICK) && !dynamic_enable);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        cmd.load    = 1'b0;
        cmd.issue   = 1'b0;
        cmd.uop     = UOP_NONE;
        cmd.publish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    op_next    = op_t'(opcode);
                    idx_next   = '0;
                    state_next = skip ? S_DONE : S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                cmd.uop   = uc.uop;
                idx_next  = idx_reg + 1'b1;
                if (uc.last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                if (can_publish)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NOP;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/rb2d_dp.sv -----
`timescale 1ns / 1ps

module rb2d_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rb2d_pkg::ctrl_cmd_t  cmd,
    input  rb2d_pkg::cfg_t       cfg,
    input  logic [15:0]          step_time,
    input  logic signed [31:0]   vec_x,
    input  logic signed [31:0]   vec_y,
    input  logic signed [31:0]   point_x,
    input  logic signed [31:0]   point_y,
    input  logic signed [31:0]   angular_value,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   rotation,
    output logic signed [31:0]   vel_x,
    output logic signed [31:0]   vel_y,
    output logic signed [31:0]   spin_rate
);
    import rb2d_pkg::*;

    // Latched input item.
    logic [15:0]        dt_reg;
    logic signed [31:0] in_vx_reg, in_vy_reg, in_px_reg, in_py_reg, in_av_reg;

    // Body state.
    logic signed [31:0] px_reg, px_next, py_reg, py_next;
    logic signed [31:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [31:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [31:0] ang_reg, ang_next, w_reg, w_next, aw_reg, aw_next;

    // Scratch registers of the sequence.
    logic signed [32:0]       df_reg, df_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [31:0]       m_reg, m_next;

    // Multiplier stage.
    logic signed [32:0]       mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_full, prod_reg, lev_sum;
    uop_t                     wb_uop_reg;

    logic signed [31:0] q_step, q_frac;
    logic signed [31:0] dx, dy;
    logic signed [32:0] neg_dy;
    logic [16:0]        keep_x, keep_y, keep_s;
    logic [32:0]        dt_ext;

    function automatic logic [16:0] keep_of(logic [16:0] r);
        logic [16:0] rs;
        rs = (r > STEP_ONE) ? STEP_ONE : r;
        return STEP_ONE - rs;
    endfunction

    assign keep_x = keep_of(cfg.restrict_x);
    assign keep_y = keep_of(cfg.restrict_y);
    assign keep_s = keep_of(cfg.restrict_spin);
    assign dt_ext = {17'd0, dt_reg};

    // Lever arm from the body origin; the moment uses its perpendicular.
    assign dx     = in_px_reg - px_reg;
    assign dy     = in_py_reg - py_reg;
    assign neg_dy = -{dy[31], dy};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.uop)
            UOP_VX_ACC:    begin mul_a = {ax_reg[31], ax_reg}; mul_b = dt_ext; end
            UOP_VY_ACC:    begin mul_a = {ay_reg[31], ay_reg}; mul_b = dt_ext; end
            UOP_VX_KEEP:   begin mul_a = {vx_reg[31], vx_reg}; mul_b = {16'd0, keep_x}; end
            UOP_VY_KEEP:   begin mul_a = {vy_reg[31], vy_reg}; mul_b = {16'd0, keep_y}; end
            UOP_LIN_DF:    begin mul_a = {2'b00, cfg.linear_drag}; mul_b = dt_ext; end
            UOP_W_ACC:     begin mul_a = {aw_reg[31], aw_reg}; mul_b = dt_ext; end
            UOP_VX_DF:     begin mul_a = {vx_reg[31], vx_reg}; mul_b = df_reg; end
            UOP_VY_DF:     begin mul_a = {vy_reg[31], vy_reg}; mul_b = df_reg; end
            UOP_W_KEEP:    begin mul_a = {w_reg[31], w_reg};   mul_b = {16'd0, keep_s}; end
            UOP_ANG_DF:    begin mul_a = {2'b00, cfg.angular_drag}; mul_b = dt_ext; end
            UOP_PX_ADD:    begin mul_a = {vx_reg[31], vx_reg}; mul_b = dt_ext; end
            UOP_W_DF:      begin mul_a = {w_reg[31], w_reg};   mul_b = df_reg; end
            UOP_PY_ADD:    begin mul_a = {vy_reg[31], vy_reg}; mul_b = dt_ext; end
            UOP_ANG_ADD:   begin mul_a = {w_reg[31], w_reg};   mul_b = dt_ext; end
            UOP_AX_FORCE,
            UOP_VX_IMP:    begin mul_a = {in_vx_reg[31], in_vx_reg};
                                 mul_b = {2'b00, cfg.inv_mass}; end
            UOP_AY_FORCE,
            UOP_VY_IMP:    begin mul_a = {in_vy_reg[31], in_vy_reg};
                                 mul_b = {2'b00, cfg.inv_mass}; end
            UOP_AW_TORQUE,
            UOP_W_IMP:     begin mul_a = {in_av_reg[31], in_av_reg};
                                 mul_b = {2'b00, cfg.inv_inertia_deg}; end
            UOP_AW_MOMENT,
            UOP_W_IMP_MOMENT:
                           begin mul_a = {m_reg[31], m_reg};
                                 mul_b = {2'b00, cfg.inv_inertia_deg}; end
            UOP_LEV_1:     begin mul_a = {in_vx_reg[31], in_vx_reg}; mul_b = neg_dy; end
            UOP_LEV_2:     begin mul_a = {in_vy_reg[31], in_vy_reg}; mul_b = {dx[31], dx}; end
            default:       begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Arithmetic shift right then wrap to 32 bits is a plain bit slice.
    assign q_step  = prod_reg[STEP_FRAC+31:STEP_FRAC];
    assign q_frac  = prod_reg[FRAC_BITS+31:FRAC_BITS];
    assign lev_sum = acc_reg + prod_reg;

    always_comb
    begin
        px_next  = px_reg;
        py_next  = py_reg;
        vx_next  = vx_reg;
        vy_next  = vy_reg;
        ax_next  = ax_reg;
        ay_next  = ay_reg;
        ang_next = ang_reg;
        w_next   = w_reg;
        aw_next  = aw_reg;
        df_next  = df_reg;
        acc_next = acc_reg;
        m_next   = m_reg;
        case (wb_uop_reg)
            UOP_VX_ACC:       vx_next  = vx_reg + q_step;
            UOP_VY_ACC:       vy_next  = vy_reg + q_step;
            UOP_VX_KEEP:      vx_next  = q_step;
            UOP_VY_KEEP:      vy_next  = q_step;
            UOP_LIN_DF,
            UOP_ANG_DF:       df_next  = DF_ONE - {2'b00, prod_reg[STEP_FRAC+30:STEP_FRAC]};
            UOP_W_ACC:        w_next   = w_reg + q_step;
            UOP_VX_DF:        vx_next  = q_frac;
            UOP_VY_DF:        vy_next  = q_frac;
            UOP_W_KEEP:       w_next   = q_step;
            UOP_PX_ADD:       px_next  = px_reg + q_step;
            UOP_W_DF:         w_next   = q_frac;
            UOP_PY_ADD:       py_next  = py_reg + q_step;
            UOP_ANG_ADD:      ang_next = ang_reg + q_step;
            UOP_AX_FORCE:     ax_next  = ax_reg + q_frac;
            UOP_AY_FORCE:     ay_next  = ay_reg + q_frac;
            UOP_AW_TORQUE,
            UOP_AW_MOMENT:    aw_next  = aw_reg + q_frac;
            UOP_LEV_1:        acc_next = prod_reg;
            UOP_LEV_2:        m_next   = lev_sum[FRAC_BITS+31:FRAC_BITS];
            UOP_VX_IMP:       vx_next  = vx_reg + q_frac;
            UOP_VY_IMP:       vy_next  = vy_reg + q_frac;
            UOP_W_IMP,
            UOP_W_IMP_MOMENT: w_next   = w_reg + q_frac;
            UOP_POSE:
            begin
                px_next  = in_px_reg;
                py_next  = in_py_reg;
                ang_next = in_av_reg;
            end
            default:          m_next   = m_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg     <= '0;
            py_reg     <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            ax_reg     <= '0;
            ay_reg     <= '0;
            ang_reg    <= '0;
            w_reg      <= '0;
            aw_reg     <= '0;
            wb_uop_reg <= UOP_NONE;
        end
        else
        begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
            ax_reg     <= ax_next;
            ay_reg     <= ay_next;
            ang_reg    <= ang_next;
            w_reg      <= w_next;
            aw_reg     <= aw_next;
            wb_uop_reg <= cmd.issue ? cmd.uop : UOP_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full;
        df_reg   <= df_next;
        acc_reg  <= acc_next;
        m_reg    <= m_next;
        if (cmd.load)
        begin
            dt_reg    <= step_time;
            in_vx_reg <= vec_x;
            in_vy_reg <= vec_y;
            in_px_reg <= point_x;
            in_py_reg <= point_y;
            in_av_reg <= angular_value;
        end
        if (cmd.publish)
        begin
            pos_x     <= px_reg;
            pos_y     <= py_reg;
            rotation  <= ang_reg;
            vel_x     <= vx_reg;
            vel_y     <= vy_reg;
            spin_rate <= w_reg;
        end
    end

endmodule

// ----- rtl/core/rigid_body_2d_integrator.sv -----
`timescale 1ns / 1ps

// 2D rigid body integrator. Each input item carries an opcode (tick, force,
// torque, force at point, impulse, impulse at point, set pose, or no-op) and
// returns exactly one result item with position, rotation, velocity and spin
// rate after the operation. Both channels use valid/ready; the body constants
// sit in an APB register file to be written by the user only while the block
// is idle, which the block does not enforce. Work runs through one shared
// 33x33 multiplier, one micro-step per cycle, with each product written back
// in the following cycle. A tick takes 14 steps, force at point and impulse
// at point 5, impulse 3, force 2, torque and set pose 1. After acceptance the
// controller issues the steps, passes a flush state for the last write-back
// and publishes the result from the done state; a static tick and the no-op
// take no steps and go straight to the done state. in_ready rises in the same
// cycle as out_valid. The result sits in an output register, so a new item is
// accepted and worked on while the receiver stalls; only publishing the
// following result waits for the register to drain. Reset clears the body
// state to zero, loads the register defaults and leaves both channels empty.
module rigid_body_2d_integrator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rb2d_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   opcode,
    input  logic [15:0]                  step_time,
    input  logic signed [31:0]           vec_x,
    input  logic signed [31:0]           vec_y,
    input  logic signed [31:0]           point_x,
    input  logic signed [31:0]           point_y,
    input  logic signed [31:0]           angular_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [31:0]           pos_x,
    output logic signed [31:0]           pos_y,
    output logic signed [31:0]           rotation,
    output logic signed [31:0]           vel_x,
    output logic signed [31:0]           vel_y,
    output logic signed [31:0]           spin_rate
);
    import rb2d_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;

    rb2d_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rb2d_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .dynamic_enable (cfg.dynamic_enable),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cmd            (cmd)
    );

    rb2d_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .step_time     (step_time),
        .vec_x         (vec_x),
        .vec_y         (vec_y),
        .point_x       (point_x),
        .point_y       (point_y),
        .angular_value (angular_value),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .rotation      (rotation),
        .vel_x         (vel_x),
        .vel_y         (vel_y),
        .spin_rate     (spin_rate)
    );

endmodule
